FILE: sv/plob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_pkg
// Shared sizes and codes of the price level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int MAX_LEVELS  = 128;
  localparam int LEVEL_DEPTH = 64;
  localparam int ID_SLOTS    = 8192;

  localparam int LVL_W    = $clog2(MAX_LEVELS);
  localparam int POS_W    = $clog2(LEVEL_DEPTH);
  localparam int CNT_W    = POS_W + 1;
  localparam int Q_W      = LVL_W + 1;
  localparam int ENT_AW   = Q_W + POS_W;
  localparam int SLOT_W   = $clog2(ID_SLOTS);
  localparam int MAP_W    = LVL_W + 2;
  localparam int LVLD_W   = POS_W + CNT_W;
  localparam int ACC_W    = 38;
  localparam int CHUNK_W  = 8;
  localparam int CHUNK_IW = LVL_W - 3;

  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_PEEK = 3'd1;
  localparam logic [2:0] ACT_POP  = 3'd2;
  localparam logic [2:0] ACT_REM  = 3'd3;
  localparam logic [2:0] ACT_CAN  = 3'd4;
  localparam logic [2:0] ACT_VOL  = 3'd5;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_EMPTY     = 3'd1;
  localparam logic [2:0] STS_BAD_PRICE = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_MISMATCH  = 3'd4;
  localparam logic [2:0] STS_NOT_FOUND = 3'd5;

  localparam logic CFG_PRICE_BASE  = 1'b0;
  localparam logic CFG_LEVEL_COUNT = 1'b1;

endpackage

FILE: sv/price_level_order_book.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book
// Two-sided order book, one FIFO per price level and side, occupancy bitmaps.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser {side,action}, tdata {volume,price,id}
// m_*      out  m_tvalid/m_tready  tuser status, tdata result fields
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One request at a time. Add writes the entry at the tail of its level;
// peek/pop/remove first scan the bitmap (8 levels a cycle) for the best
// level and then read its head entry; cancel walks the level comparing
// ids and shifts the later entries down; volume query sums the entries of
// both levels. After reset the id map is cleared, all 8192 slots, before
// s_tready rises. A stalled result holds the block in its output state.
// ----------------------------------------------------------------------------
module price_level_order_book
  import plob_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // order_id[63:0], price[79:64], volume[111:80]
  input  logic [3:0]   s_tuser,   // action[2:0], side[3]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // out_order_id, out_price, out_volume,
                                  // bid_volume, ask_volume, zero pad
  output logic [2:0]   m_tuser,   // status[2:0]
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_ADD_DO  = 5'd2;
  localparam logic [4:0] S_SCAN    = 5'd3;
  localparam logic [4:0] S_BEST_W  = 5'd4;
  localparam logic [4:0] S_BEST_E  = 5'd5;
  localparam logic [4:0] S_BEST_EW = 5'd6;
  localparam logic [4:0] S_BEST_DO = 5'd7;
  localparam logic [4:0] S_CAN_CHK = 5'd8;
  localparam logic [4:0] S_CAN_LW  = 5'd9;
  localparam logic [4:0] S_CAN_LVL = 5'd10;
  localparam logic [4:0] S_CW_W    = 5'd11;
  localparam logic [4:0] S_CW_CMP  = 5'd12;
  localparam logic [4:0] S_SH_W    = 5'd13;
  localparam logic [4:0] S_SH_WR   = 5'd14;
  localparam logic [4:0] S_VOL_LW  = 5'd15;
  localparam logic [4:0] S_VOL_LVL = 5'd16;
  localparam logic [4:0] S_VOL_W   = 5'd17;
  localparam logic [4:0] S_VOL_ACC = 5'd18;
  localparam logic [4:0] S_OUT     = 5'd19;

  logic [4:0]  state;
  logic [15:0] price_base;
  logic [7:0]  level_count;

  logic [2:0]       act_r;
  logic             side_r;
  logic [63:0]      id_r;
  logic [31:0]      vol_r;
  logic [LVL_W-1:0] lv_r;
  logic             bad_r;
  logic [POS_W-1:0] head_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] k_r;
  logic [CHUNK_IW-1:0] chunk_r;
  logic [ACC_W-1:0] acc_r;

  logic [2:0]       res_status;
  logic [63:0]      res_id;
  logic [15:0]      res_price;
  logic [31:0]      res_vol;
  logic [ACC_W-1:0] res_bv;
  logic [ACC_W-1:0] res_av;

  logic [2:0]       m_status;
  logic [63:0]      m_id;
  logic [15:0]      m_price;
  logic [31:0]      m_vol;
  logic [ACC_W-1:0] m_bv;
  logic [ACC_W-1:0] m_av;

  logic [2*MAX_LEVELS-1:0] occ;
  logic [2*MAX_LEVELS-1:0] lvl_vld;
  logic                    lvl_rv;
  logic [SLOT_W:0]         clr_cnt;
  logic                    clr_busy;

  // input decode
  logic [15:0] in_price;
  logic [15:0] in_diff;
  logic [15:0] in_lc;
  logic        in_bad;
  logic [2:0]  in_act;

  assign in_act   = s_tuser[2:0];
  assign in_price = s_tdata[79:64];
  assign in_diff  = in_price - price_base;
  assign in_lc    = (level_count > 8'(MAX_LEVELS)) ? 16'(MAX_LEVELS) : {8'd0, level_count};
  assign in_bad   = (in_price < price_base) || (in_diff >= in_lc);

  assign clr_busy = !clr_cnt[SLOT_W];
  assign s_tready = (state == S_IDLE) && !clr_busy;

  // memories
  logic              ent_we;
  logic [ENT_AW-1:0] ent_wa;
  logic [95:0]       ent_wd;
  logic [ENT_AW-1:0] ent_ra;
  logic [95:0]       ent_rd;
  logic              lvl_we;
  logic [LVLD_W-1:0] lvl_wd;
  logic [Q_W-1:0]    q_addr;
  logic [LVLD_W-1:0] lvl_rd;
  logic              id_we;
  logic [SLOT_W-1:0] id_wa;
  logic [MAP_W-1:0]  id_wd;
  logic [MAP_W-1:0]  id_rd;

  assign q_addr = {side_r, lv_r};
  assign ent_ra = {q_addr, POS_W'(head_r + k_r[POS_W-1:0])};

  plob_ram #(.AW(ENT_AW), .DW(96)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
    .raddr(ent_ra), .rdata(ent_rd)
  );

  plob_ram #(.AW(Q_W), .DW(LVLD_W)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(q_addr), .wdata(lvl_wd),
    .raddr(q_addr), .rdata(lvl_rd)
  );

  plob_ram #(.AW(SLOT_W), .DW(MAP_W)) u_idmap (
    .clk(clk), .we(id_we), .waddr(id_wa), .wdata(id_wd),
    .raddr(id_r[SLOT_W-1:0]), .rdata(id_rd)
  );

  logic [POS_W-1:0] cur_head;
  logic [CNT_W-1:0] cur_cnt;
  assign cur_head = lvl_rv ? lvl_rd[LVLD_W-1:CNT_W] : '0;
  assign cur_cnt  = lvl_rv ? lvl_rd[CNT_W-1:0] : '0;

  // bitmap chunk search
  logic [CHUNK_W-1:0] cb;
  logic [2:0]         cb_pos;
  logic               cb_found;
  assign cb       = occ[{side_r, chunk_r, 3'b000} +: CHUNK_W];
  assign cb_found = |cb;

  always_comb begin
    cb_pos = '0;
    if (!side_r) begin
      for (int i = 0; i < CHUNK_W; i++) begin
        if (cb[i]) cb_pos = 3'(i);
      end
    end else begin
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
        if (cb[i]) cb_pos = 3'(i);
      end
    end
  end

  logic id_match;
  assign id_match = (ent_rd[95:32] == id_r);

  logic occ_set;
  logic occ_clr;

  always_comb begin
    ent_we  = 1'b0;
    ent_wa  = ent_ra;
    ent_wd  = ent_rd;
    lvl_we  = 1'b0;
    lvl_wd  = {head_r, cnt_r};
    id_we   = 1'b0;
    id_wa   = id_r[SLOT_W-1:0];
    id_wd   = '0;
    occ_set = 1'b0;
    occ_clr = 1'b0;
    unique case (state)
      S_ADD_DO: begin
        if (!cur_cnt[CNT_W-1]) begin
          ent_we  = 1'b1;
          ent_wa  = {q_addr, POS_W'(cur_head + cur_cnt[POS_W-1:0])};
          ent_wd  = {id_r, vol_r};
          lvl_we  = 1'b1;
          lvl_wd  = {cur_head, CNT_W'(cur_cnt + 1'b1)};
          occ_set = 1'b1;
          id_we   = 1'b1;
          id_wd   = {1'b1, side_r, lv_r};
        end
      end
      S_BEST_DO: begin
        if (!(act_r == ACT_REM && !id_match)) begin
          if (act_r != ACT_PEEK) begin
            lvl_we  = 1'b1;
            lvl_wd  = {POS_W'(head_r + 1'b1), CNT_W'(cnt_r - 1'b1)};
            occ_clr = (cnt_r == CNT_W'(1));
          end
          id_we = (act_r == ACT_REM);
        end
      end
      S_CW_CMP: begin
        id_we = (k_r == cnt_r);
      end
      S_SH_WR: begin
        if (k_r < cnt_r) begin
          ent_we = 1'b1;
          ent_wa = {q_addr, POS_W'(head_r + k_r[POS_W-1:0] - 1'b1)};
        end else begin
          lvl_we  = 1'b1;
          lvl_wd  = {head_r, CNT_W'(cnt_r - 1'b1)};
          occ_clr = (cnt_r == CNT_W'(1));
          id_we   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (clr_busy) begin
      id_we = 1'b1;
      id_wa = clr_cnt[SLOT_W-1:0];
      id_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      price_base  <= 16'd950;
      level_count <= 8'd101;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRICE_BASE:  price_base  <= cfg_data;
        CFG_LEVEL_COUNT: level_count <= cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lvl_rv <= lvl_vld[q_addr];
    if (rst) begin
      lvl_vld <= '0;
      occ     <= '0;
      clr_cnt <= '0;
    end else begin
      if (clr_busy) clr_cnt <= clr_cnt + 1'b1;
      if (lvl_we) lvl_vld[q_addr] <= 1'b1;
      if (occ_set) occ[q_addr] <= 1'b1;
      if (occ_clr) occ[q_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && (state != S_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            act_r      <= in_act;
            side_r     <= (in_act == ACT_VOL) ? 1'b0 : s_tuser[3];
            id_r       <= s_tdata[63:0];
            vol_r      <= s_tdata[111:80];
            lv_r       <= in_diff[LVL_W-1:0];
            bad_r      <= in_bad;
            acc_r      <= '0;
            res_status <= STS_OK;
            res_id     <= '0;
            res_price  <= '0;
            res_vol    <= '0;
            res_bv     <= '0;
            res_av     <= '0;
            state      <= S_DISP;
          end
        end
        S_DISP: begin
          priority case (act_r)
            ACT_ADD, ACT_VOL: begin
              if (bad_r) begin
                res_status <= STS_BAD_PRICE;
                state      <= S_OUT;
              end else begin
                state <= (act_r == ACT_ADD) ? S_ADD_DO : S_VOL_LVL;
              end
            end
            ACT_PEEK, ACT_POP, ACT_REM: begin
              chunk_r <= side_r ? '0 : '1;
              state   <= S_SCAN;
            end
            ACT_CAN: state <= S_CAN_CHK;
            default: state <= S_OUT;
          endcase
        end
        S_ADD_DO: begin
          if (cur_cnt[CNT_W-1]) res_status <= STS_FULL;
          state <= S_OUT;
        end
        S_SCAN: begin
          if (cb_found) begin
            lv_r  <= {chunk_r, cb_pos};
            state <= S_BEST_W;
          end else if (chunk_r == (side_r ? '1 : '0)) begin
            res_status <= STS_EMPTY;
            state      <= S_OUT;
          end else begin
            chunk_r <= side_r ? CHUNK_IW'(chunk_r + 1'b1) : CHUNK_IW'(chunk_r - 1'b1);
          end
        end
        S_BEST_W: state <= S_BEST_E;
        S_BEST_E: begin
          head_r <= cur_head;
          cnt_r  <= cur_cnt;
          k_r    <= '0;
          state  <= S_BEST_EW;
        end
        S_BEST_EW: state <= S_BEST_DO;
        S_BEST_DO: begin
          if (act_r == ACT_REM && !id_match) begin
            res_status <= STS_MISMATCH;
          end else begin
            res_id    <= ent_rd[95:32];
            res_vol   <= ent_rd[31:0];
            res_price <= price_base + 16'(lv_r);
          end
          state <= S_OUT;
        end
        S_CAN_CHK: begin
          if (!id_rd[MAP_W-1]) begin
            res_status <= STS_NOT_FOUND;
            state      <= S_OUT;
          end else begin
            side_r <= id_rd[MAP_W-2];
            lv_r   <= id_rd[LVL_W-1:0];
            state  <= S_CAN_LW;
          end
        end
        S_CAN_LW: state <= S_CAN_LVL;
        S_CAN_LVL: begin
          head_r <= cur_head;
          cnt_r  <= cur_cnt;
          k_r    <= '0;
          state  <= S_CW_W;
        end
        S_CW_W: state <= S_CW_CMP;
        S_CW_CMP: begin
          k_r <= k_r + 1'b1;
          if (k_r == cnt_r) begin
            state <= S_OUT;
          end else if (id_match) begin
            state <= S_SH_W;
          end else begin
            state <= S_CW_W;
          end
        end
        S_SH_W: state <= S_SH_WR;
        S_SH_WR: begin
          if (k_r < cnt_r) begin
            k_r   <= k_r + 1'b1;
            state <= S_SH_W;
          end else begin
            state <= S_OUT;
          end
        end
        S_VOL_LW: state <= S_VOL_LVL;
        S_VOL_LVL: begin
          head_r <= cur_head;
          cnt_r  <= cur_cnt;
          k_r    <= '0;
          state  <= S_VOL_W;
        end
        S_VOL_W: state <= S_VOL_ACC;
        S_VOL_ACC: begin
          if (k_r == cnt_r) begin
            if (!side_r) begin
              res_bv <= acc_r;
              acc_r  <= '0;
              side_r <= 1'b1;
              state  <= S_VOL_LW;
            end else begin
              res_av <= acc_r;
              state  <= S_OUT;
            end
          end else begin
            acc_r <= acc_r + ACC_W'(ent_rd[31:0]);
            k_r   <= k_r + 1'b1;
            state <= S_VOL_W;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_status <= res_status;
            m_id     <= res_id;
            m_price  <= res_price;
            m_vol    <= res_vol;
            m_bv     <= res_bv;
            m_av     <= res_av;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = m_status;
  assign m_tdata = {4'd0, m_av, m_bv, m_vol, m_price, m_id};

`ifndef SYNTHESIS
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready) else $error("request taken during id map clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second request while busy");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && (!m_tvalid || m_tready) |=> m_tvalid && (state == S_IDLE))
    else $error("result not loaded");
`endif

endmodule

FILE: sv/plob_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module plob_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
